>>> src/mfm_pkg.sv
// ----------------------------------------------------------------------------
// Motor fault monitor package
// Shared types, register indexes, reset values and state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfm_pkg;

  // Default width of the internal time base.
  localparam int unsigned TimeWidthDef = 32;

  // Configuration port geometry.
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Register indexes.
  localparam logic [CfgIdxWidth-1:0] RegCurrentLimit  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegOverSpeedLim  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegStallTgtMin   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegStallSpeedMax = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegStallTime     = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegLockCount     = 3'd5;

  // Register reset values.
  localparam logic [15:0] CurrentLimitRst  = 16'd65535;
  localparam logic [14:0] OverSpeedLimRst  = 15'd32767;
  localparam logic [14:0] StallTgtMinRst   = 15'd100;
  localparam logic [14:0] StallSpeedMaxRst = 15'd10;
  localparam logic [15:0] StallTimeRst     = 16'd2000;
  localparam logic [7:0]  LockCountRst     = 8'd5;

  // Motor mode codes.
  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeRun    = 2'd1;
  localparam logic [1:0] ModeError  = 2'd2;
  localparam logic [1:0] ModeLocked = 2'd3;

  // Error codes.
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrOverCurr  = 2'd1;
  localparam logic [1:0] ErrStall     = 2'd2;
  localparam logic [1:0] ErrOverSpeed = 2'd3;

  // Saturation limit of the error counter.
  localparam logic [7:0] CountMax = 8'd255;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] current_limit;
    logic [14:0] spd_limit;
    logic [14:0] stall_target_min;
    logic [14:0] stall_speed_max;
    logic [15:0] stall_time;
    logic [7:0]  lock_count;
  } cfg_t;

  // One protection check item.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] measured_current;
    logic [15:0] measured_speed;
    logic [15:0] reported_speed;
    logic [14:0] speed_cmd;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] error_bits;
    logic [1:0] fault_code;
    logic [1:0] fault_state;
    logic [7:0] fault_count;
    logic [2:0] protection_flags;
  } result_t;

  // Magnitude of a two's complement 16-bit value; -32768 gives 32768.
  function automatic logic [15:0] abs16(input logic [15:0] v);
    logic [15:0] r;
    r = v[15] ? (16'd0 - v) : v;
    return r;
  endfunction

endpackage

>>> src/mfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Motor fault monitor configuration registers
// Holds the six limit registers, written through an indexed write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfm_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mfm_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [mfm_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output mfm_pkg::cfg_t                       cfg_o
);
  import mfm_pkg::*;

  cfg_t cfg_q;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  // Indexed write; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_limit    <= CurrentLimitRst;
      cfg_q.spd_limit        <= OverSpeedLimRst;
      cfg_q.stall_target_min <= StallTgtMinRst;
      cfg_q.stall_speed_max  <= StallSpeedMaxRst;
      cfg_q.stall_time       <= StallTimeRst;
      cfg_q.lock_count       <= LockCountRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCurrentLimit:  cfg_q.current_limit    <= cfg_data_i;
        RegOverSpeedLim:  cfg_q.spd_limit        <= cfg_data_i[14:0];
        RegStallTgtMin:   cfg_q.stall_target_min <= cfg_data_i[14:0];
        RegStallSpeedMax: cfg_q.stall_speed_max  <= cfg_data_i[14:0];
        RegStallTime:     cfg_q.stall_time       <= cfg_data_i;
        RegLockCount:     cfg_q.lock_count       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/mfm_check.sv
// ----------------------------------------------------------------------------
// Motor fault monitor check core
// Evaluates one registered check item against the limits and updates the
// stall timer, error counter, error code and motor mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfm_check #(
  parameter int unsigned TimeWidth = mfm_pkg::TimeWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mfm_pkg::item_t    item_i,
  input  mfm_pkg::cfg_t     cfg_i,
  output mfm_pkg::result_t  result_o
);
  import mfm_pkg::*;

  logic                 stall_timing_q, stall_timing_d;
  logic [TimeWidth-1:0] stall_begin_q, stall_begin_d;
  logic [7:0]           err_cnt_q, err_cnt_d;
  logic [1:0]           err_code_q, err_code_d;
  logic [1:0]           mode_q, mode_d;

  logic [TimeWidth-1:0] now;
  logic [TimeWidth-1:0] elapsed;
  logic [15:0]          meas_abs;
  logic [15:0]          rep_abs;
  logic                 over_curr;
  logic                 stall_cond;
  logic                 stall_err;
  logic                 spd_over;
  logic [2:0]           errors;
  logic [7:0]           cnt_inc;
  logic [7:0]           cnt_dec;

  // Limit compares.
  assign now        = TimeWidth'(item_i.now_ms);
  assign meas_abs   = abs16(item_i.measured_speed);
  assign rep_abs    = abs16(item_i.reported_speed);
  assign over_curr  = item_i.measured_current > cfg_i.current_limit;
  assign stall_cond = (item_i.speed_cmd > cfg_i.stall_target_min) &&
                      (meas_abs < {1'b0, cfg_i.stall_speed_max});
  assign spd_over   = rep_abs > {1'b0, cfg_i.spd_limit};

  // Stall timeout counts only once the onset has been recorded.
  assign elapsed   = now - stall_begin_q;
  assign stall_err = stall_cond && stall_timing_q &&
                     (elapsed > TimeWidth'(cfg_i.stall_time));

  assign errors  = {spd_over, stall_err, over_curr};
  assign cnt_inc = (err_cnt_q == CountMax) ? err_cnt_q : err_cnt_q + 8'd1;
  assign cnt_dec = (err_cnt_q != 8'd0) ? err_cnt_q - 8'd1 : err_cnt_q;

  // Next state of the stall timer.
  always_comb begin
    stall_timing_d = stall_timing_q;
    stall_begin_d  = stall_begin_q;
    if (stall_cond) begin
      if (!stall_timing_q) begin
        stall_timing_d = 1'b1;
        stall_begin_d  = now;
      end
    end else begin
      stall_timing_d = 1'b0;
      stall_begin_d  = '0;
    end
  end

  // Next error code, counter and mode; the later check's code wins.
  always_comb begin
    err_code_d = err_code_q;
    err_cnt_d  = err_cnt_q;
    mode_d     = mode_q;
    if (spd_over) begin
      err_code_d = ErrOverSpeed;
    end else if (stall_err) begin
      err_code_d = ErrStall;
    end else if (over_curr) begin
      err_code_d = ErrOverCurr;
    end
    if (errors != 3'b000) begin
      err_cnt_d = cnt_inc;
      mode_d    = (cnt_inc > cfg_i.lock_count) ? ModeLocked : ModeError;
    end else begin
      err_cnt_d = cnt_dec;
      if (cnt_dec == 8'd0) begin
        err_code_d = ErrNone;
        mode_d     = (item_i.speed_cmd != 15'd0) ? ModeRun : ModeIdle;
      end
    end
  end

  // Check state advances once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_timing_q <= 1'b0;
      stall_begin_q  <= '0;
      err_cnt_q      <= 8'd0;
      err_code_q     <= ErrNone;
      mode_q         <= ModeIdle;
    end else if (step_i) begin
      stall_timing_q <= stall_timing_d;
      stall_begin_q  <= stall_begin_d;
      err_cnt_q      <= err_cnt_d;
      err_code_q     <= err_code_d;
      mode_q         <= mode_d;
    end
  end

  // Result of this item.
  always_comb begin
    result_o.error_bits       = errors;
    result_o.fault_code       = err_code_d;
    result_o.fault_state      = mode_d;
    result_o.fault_count      = err_cnt_d;
    result_o.protection_flags = {spd_over, stall_cond, over_curr};
  end

endmodule

>>> src/motor_fault_monitor.sv
// Each item is held in the input register and its result in the result register.
// Throughput: one item per cycle while the result side takes results; the check
// state feeds back through its next-state logic. The two registers part the channels,
// so a new item is taken into an empty input register while a finished result waits.
// Reset (rst_ni low, asynchronous) clears the check state and both valids
// and loads the limit registers with their defaults.
// ----------------------------------------------------------------------------
// Motor fault monitor
// Over-current, stall-timeout and over-speed protection with an error
// counter and idle, run, error and locked modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_fault_monitor #(
  parameter int unsigned TimeWidth = mfm_pkg::TimeWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mfm_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [mfm_pkg::CfgDataWidth-1:0] cfg_data_i,
  // Check input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [31:0]                      now_ms_i,
  input  logic [15:0]                      measured_current_i,
  input  logic signed [15:0]               measured_speed_i,
  input  logic signed [15:0]               reported_speed_i,
  input  logic [14:0]                      speed_cmd_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       error_bits_o,
  output logic [1:0]                       fault_code_o,
  output logic [1:0]                       fault_state_o,
  output logic [7:0]                       fault_count_o,
  output logic [2:0]                       protection_flags_o
);
  import mfm_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;

  // Limit registers.
  mfm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline control: the stage moves on when the result register frees up.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.now_ms           <= now_ms_i;
      in_item_q.measured_current <= measured_current_i;
      in_item_q.measured_speed   <= measured_speed_i;
      in_item_q.reported_speed   <= reported_speed_i;
      in_item_q.speed_cmd        <= speed_cmd_i;
    end
  end

  // Protection check and its state.
  mfm_check #(
    .TimeWidth (TimeWidth)
  ) u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign error_bits_o       = res_q.error_bits;
  assign fault_code_o       = res_q.fault_code;
  assign fault_state_o      = res_q.fault_state;
  assign fault_count_o      = res_q.fault_count;
  assign protection_flags_o = res_q.protection_flags;

endmodule

>>> src/mfm_checker.sv
// ----------------------------------------------------------------------------
// Motor fault monitor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] error_bits_o,
  input logic [1:0] fault_code_o,
  input logic [1:0] fault_state_o,
  input logic [7:0] fault_count_o,
  input logic [2:0] protection_flags_o
);
  import mfm_pkg::*;

  // A stalled result item holds its valid, error bits, count, mode and code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(error_bits_o) && $stable(fault_count_o) &&
      $stable(fault_state_o) && $stable(fault_code_o))
    else $error("stalled result item changed");

  // A check with errors leaves the block in the error or locked mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_bits_o != 3'b000) |->
      (fault_state_o == ModeError || fault_state_o == ModeLocked) &&
      (fault_count_o != 8'd0) && (fault_code_o != ErrNone))
    else $error("error item without error mode");

  // A zero count means the error code is clear and the mode is idle or run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fault_count_o == 8'd0) |->
      (fault_code_o == ErrNone) &&
      (fault_state_o == ModeIdle || fault_state_o == ModeRun))
    else $error("zero count with pending error");

  // Error bits agree with the condition flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (error_bits_o[0] == protection_flags_o[0]) &&
      (error_bits_o[2] == protection_flags_o[2]) &&
      (!error_bits_o[1] || protection_flags_o[1]))
    else $error("error bits disagree with flags");

endmodule

bind motor_fault_monitor mfm_checker u_mfm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .error_bits_o       (error_bits_o),
  .fault_code_o       (fault_code_o),
  .fault_state_o      (fault_state_o),
  .fault_count_o      (fault_count_o),
  .protection_flags_o (protection_flags_o)
);

>>> test/motor_fault_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor fault monitor testbench
// Drives protection checks through the valid/ready input channel, predicts
// each result with a cycle-free model of the check, and compares every
// delivered result field by field. A directed table comes first, then a
// saturation run of the error counter, then random phases over several
// limit settings with random idling on both channels and one long stall of
// the result side.
// ----------------------------------------------------------------------------

module motor_fault_monitor_tb;

  import mfm_pkg::*;

  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned RandPhases  = 8;
  localparam int unsigned PhaseItems  = 60;
  localparam int unsigned FullItems   = 270;
  localparam int unsigned RunLimitNs  = 5_000_000;

  // Register indexes past the end of the list; writes to them are ignored.
  localparam logic [CfgIdxWidth-1:0] RegBeyondLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegBeyondHi = 3'd7;

  // Most negative 16-bit speed; its magnitude does not fit in 15 bits.
  localparam logic [15:0] SpeedMostNeg = 16'h8000;

  typedef enum logic [1:0] {
    RowCheck,
    RowTyped,
    RowLimit
  } row_kind_e;

  // One line of the directed table.
  typedef struct packed {
    row_kind_e               kind;
    logic [CfgIdxWidth-1:0]  reg_idx;
    logic [15:0]             reg_data;
    item_t                   chk;
    result_t                 res;
  } stim_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    cfg_valid   = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index   = '0;
  logic [CfgDataWidth-1:0] cfg_data    = '0;
  logic                    chk_valid   = 1'b0;
  logic [31:0]             chk_now     = '0;
  logic [15:0]             chk_current = '0;
  logic [15:0]             chk_meas    = '0;
  logic [15:0]             chk_rep     = '0;
  logic [14:0]             chk_target  = '0;
  logic                    res_ready   = 1'b0;

  logic       cfg_ready_o;
  logic       chk_ready_o;
  logic       res_valid_o;
  logic [2:0] error_bits_o;
  logic [1:0] fault_code_o;
  logic [1:0] fault_state_o;
  logic [7:0] fault_count_o;
  logic [2:0] protection_flags_o;

  // Predicted check state and limit registers.
  cfg_t        cfg_q;
  logic        stall_timing_q;
  logic [31:0] stall_begin_q;
  logic [7:0]  count_q;
  logic [1:0]  code_q;
  logic [1:0]  mode_q;

  // Results owed by the block, oldest first.
  result_t results_due[$];

  int unsigned fail_count      = 0;
  bit          sender_steady   = 1'b0;
  bit          receiver_steady = 1'b0;
  bit          hold_off        = 1'b0;
  logic [31:0] clock_ms        = 32'hFFFF_0000;
  bit          stall_episode   = 1'b0;

  motor_fault_monitor i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (chk_valid),
    .in_ready_o         (chk_ready_o),
    .now_ms_i           (chk_now),
    .measured_current_i (chk_current),
    .measured_speed_i   (chk_meas),
    .reported_speed_i   (chk_rep),
    .speed_cmd_i        (chk_target),
    .out_valid_o        (res_valid_o),
    .out_ready_i        (res_ready),
    .error_bits_o       (error_bits_o),
    .fault_code_o       (fault_code_o),
    .fault_state_o      (fault_state_o),
    .fault_count_o      (fault_count_o),
    .protection_flags_o (protection_flags_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runaway guard.
  initial begin : watchdog
    #(RunLimitNs);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // A value within two of a limit, kept inside 0..top.
  function automatic int unsigned near_limit(input int unsigned lim, input int unsigned top);
    int v;
    v = int'(lim) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > int'(top)) v = int'(top);
    return v;
  endfunction

  // Two's complement speed of the given magnitude with a random sign.
  function automatic logic [15:0] signed_speed(input int unsigned mag);
    logic [15:0] m;
    m = mag[15:0];
    return ($urandom_range(0, 1) != 0) ? (16'd0 - m) : m;
  endfunction

  // Expected result of one check; advances the predicted state.
  function automatic result_t predict_check(input item_t it);
    result_t     r;
    logic [15:0] meas_mag;
    logic [15:0] rep_mag;
    logic [31:0] elapsed;
    r        = '0;
    meas_mag = it.measured_speed[15] ? (16'd0 - it.measured_speed) : it.measured_speed;
    rep_mag  = it.reported_speed[15] ? (16'd0 - it.reported_speed) : it.reported_speed;

    if (it.measured_current > cfg_q.current_limit) begin
      r.protection_flags[0] = 1'b1;
      r.error_bits[0]       = 1'b1;
      code_q                = ErrOverCurr;
    end

    // The first stalled check only starts the timer.
    if (it.speed_cmd > cfg_q.stall_target_min &&
        meas_mag < {1'b0, cfg_q.stall_speed_max}) begin
      r.protection_flags[1] = 1'b1;
      if (!stall_timing_q) begin
        stall_timing_q = 1'b1;
        stall_begin_q  = it.now_ms;
      end else begin
        elapsed = it.now_ms - stall_begin_q;
        if (elapsed > {16'd0, cfg_q.stall_time}) begin
          r.error_bits[1] = 1'b1;
          code_q          = ErrStall;
        end
      end
    end else begin
      stall_timing_q = 1'b0;
      stall_begin_q  = '0;
    end

    if (rep_mag > {1'b0, cfg_q.spd_limit}) begin
      r.protection_flags[2] = 1'b1;
      r.error_bits[2]       = 1'b1;
      code_q                = ErrOverSpeed;
    end

    // Saturating error counter and mode update.
    if (r.error_bits != 3'b000) begin
      if (count_q != CountMax) count_q = count_q + 8'd1;
      mode_q = (count_q > cfg_q.lock_count) ? ModeLocked : ModeError;
    end else begin
      if (count_q != 8'd0) count_q = count_q - 8'd1;
      if (count_q == 8'd0) begin
        code_q = ErrNone;
        mode_q = (it.speed_cmd != 15'd0) ? ModeRun : ModeIdle;
      end
    end

    r.fault_code  = code_q;
    r.fault_state = mode_q;
    r.fault_count = count_q;
    return r;
  endfunction

  // Random check, biased toward the limit edges and toward stall episodes
  // whose time stamps advance slowly enough to cross the stall timeout.
  function automatic item_t random_check();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      clock_ms = $urandom();
    end else if (pick < 20 && stall_timing_q) begin
      clock_ms = stall_begin_q + cfg_q.stall_time + $urandom_range(0, 1);
    end else begin
      clock_ms = clock_ms + $urandom_range(0, cfg_q.stall_time / 4 + 40);
    end
    it.now_ms = clock_ms;

    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      it.measured_current = 16'(near_limit(cfg_q.current_limit, 16'hFFFF));
    end else if (pick < 8) begin
      it.measured_current = 16'($urandom_range(0, cfg_q.current_limit));
    end else begin
      it.measured_current = 16'($urandom());
    end

    if ($urandom_range(0, 9) == 0) stall_episode = !stall_episode;
    if (stall_episode) begin
      it.speed_cmd = ($urandom_range(0, 9) < 3) ?
                     15'(near_limit(cfg_q.stall_target_min, 15'h7FFF)) :
                     15'($urandom_range(cfg_q.stall_target_min, 15'h7FFF));
      it.measured_speed = signed_speed(($urandom_range(0, 9) < 5) ?
                                       near_limit(cfg_q.stall_speed_max, 15'h7FFF) :
                                       $urandom_range(0, cfg_q.stall_speed_max));
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        it.speed_cmd = '0;
      end else if (pick < 5) begin
        it.speed_cmd = 15'(near_limit(cfg_q.stall_target_min, 15'h7FFF));
      end else begin
        it.speed_cmd = 15'($urandom());
      end
      it.measured_speed = 16'($urandom());
    end

    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      it.reported_speed = signed_speed(near_limit(cfg_q.spd_limit, 15'h7FFF));
    end else if (pick < 17) begin
      it.reported_speed = signed_speed($urandom_range(0, cfg_q.spd_limit));
    end else begin
      it.reported_speed = 16'($urandom());
    end
    return it;
  endfunction

  // Offer one check and record what it owes once it is taken.
  task automatic send_check(input item_t it, input bit has_fixed, input result_t fixed_res);
    int unsigned gap;
    result_t     due;
    gap = sender_steady ? 0 : pick_gap();
    if (gap != 0) begin
      chk_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chk_valid   <= 1'b1;
    chk_now     <= it.now_ms;
    chk_current <= it.measured_current;
    chk_meas    <= it.measured_speed;
    chk_rep     <= it.reported_speed;
    chk_target  <= it.speed_cmd;
    do @(posedge clk); while (!chk_ready_o);
    due = predict_check(it);
    results_due.push_back(has_fixed ? fixed_res : due);
  endtask

  // Stop offering checks and let the block run dry.
  task automatic settle();
    chk_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // One register write; the predicted copy follows at the handshake.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      RegCurrentLimit:  cfg_q.current_limit    = data;
      RegOverSpeedLim:  cfg_q.spd_limit        = data[14:0];
      RegStallTgtMin:   cfg_q.stall_target_min = data[14:0];
      RegStallSpeedMax: cfg_q.stall_speed_max  = data[14:0];
      RegStallTime:     cfg_q.stall_time       = data;
      RegLockCount:     cfg_q.lock_count       = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_limits(input logic [15:0] cur_lim, input logic [15:0] spd_lim,
                             input logic [15:0] tgt_min, input logic [15:0] spd_max,
                             input logic [15:0] stl_time, input logic [15:0] lock_lim);
    settle();
    write_reg(RegCurrentLimit, cur_lim);
    write_reg(RegOverSpeedLim, spd_lim);
    write_reg(RegStallTgtMin, tgt_min);
    write_reg(RegStallSpeedMax, spd_max);
    write_reg(RegStallTime, stl_time);
    write_reg(RegLockCount, lock_lim);
  endtask

  function automatic stim_row_t row_chk(input logic [31:0] now, input logic [15:0] cur,
                                        input logic [15:0] meas, input logic [15:0] rep,
                                        input logic [14:0] tgt);
    stim_row_t r;
    r      = '0;
    r.kind = RowCheck;
    r.chk  = '{now_ms: now, measured_current: cur, measured_speed: meas,
               reported_speed: rep, speed_cmd: tgt};
    return r;
  endfunction

  function automatic stim_row_t row_exp(input stim_row_t base, input logic [2:0] bits,
                                        input logic [1:0] code, input logic [1:0] mode,
                                        input logic [7:0] cnt, input logic [2:0] flags);
    stim_row_t r;
    r      = base;
    r.kind = RowTyped;
    r.res  = '{error_bits: bits, fault_code: code, fault_state: mode,
               fault_count: cnt, protection_flags: flags};
    return r;
  endfunction

  function automatic stim_row_t row_lim(input logic [CfgIdxWidth-1:0] idx,
                                        input logic [15:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = RowLimit;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_taker
    int unsigned idle;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        res_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
      end
      idle = receiver_steady ? 0 : pick_gap();
      if (idle != 0) begin
        res_ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Compare each delivered result with the oldest one owed.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && res_valid_o && res_ready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = results_due.pop_front();
        if (error_bits_o != want.error_bits)
          flag_mismatch("error_bits", error_bits_o, want.error_bits);
        if (fault_code_o != want.fault_code)
          flag_mismatch("fault_code", fault_code_o, want.fault_code);
        if (fault_state_o != want.fault_state)
          flag_mismatch("fault_state", fault_state_o, want.fault_state);
        if (fault_count_o != want.fault_count)
          flag_mismatch("fault_count", fault_count_o, want.fault_count);
        if (protection_flags_o != want.protection_flags)
          flag_mismatch("protection_flags", protection_flags_o, want.protection_flags);
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    stim_row_t   dir_rows[$];
    item_t       it;
    int unsigned phase;

    cfg_q = '{current_limit: CurrentLimitRst, spd_limit: OverSpeedLimRst,
              stall_target_min: StallTgtMinRst, stall_speed_max: StallSpeedMaxRst,
              stall_time: StallTimeRst, lock_count: LockCountRst};
    stall_timing_q = 1'b0;
    stall_begin_q  = '0;
    count_q        = '0;
    code_q         = ErrNone;
    mode_q         = ModeIdle;

    // Directed checks at the reset limits. Covers field extremes, each
    // fault, the stall timer across the time wrap, a count that stays
    // above zero on a clean check, and locking.
    dir_rows = '{
      row_exp(row_chk(32'd0, 16'h0000, 16'h0000, 16'h0000, 15'd0),
              3'b000, ErrNone, ModeIdle, 8'd0, 3'b000),
      row_exp(row_chk(32'd1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 15'h7FFF),
              3'b000, ErrNone, ModeRun, 8'd0, 3'b000),
      row_exp(row_chk(32'd2, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
              3'b100, ErrOverSpeed, ModeError, 8'd1, 3'b100),
      row_exp(row_chk(32'd3, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
              3'b100, ErrOverSpeed, ModeError, 8'd2, 3'b100),
      row_exp(row_chk(32'd4, 16'hFFFF, SpeedMostNeg, 16'h7FFF, 15'd5),
              3'b000, ErrOverSpeed, ModeError, 8'd1, 3'b000),
      row_exp(row_chk(32'd5, 16'h0000, 16'h0000, 16'h0000, 15'd0),
              3'b000, ErrNone, ModeIdle, 8'd0, 3'b000),
      // Stall timer starts just before the time stamp wraps.
      row_exp(row_chk(32'hFFFF_FC00, 16'h0000, 16'h0000, 16'h0000, 15'd101),
              3'b000, ErrNone, ModeRun, 8'd0, 3'b010),
      row_exp(row_chk(32'h0000_03D0, 16'h0000, 16'h0000, 16'h0000, 15'd101),
              3'b000, ErrNone, ModeRun, 8'd0, 3'b010),
      row_exp(row_chk(32'h0000_03D1, 16'h0000, 16'h0000, 16'h0000, 15'd101),
              3'b010, ErrStall, ModeError, 8'd1, 3'b010),
      // Stall and over-speed together: the later code wins.
      row_exp(row_chk(32'h0000_03D2, 16'h0000, 16'hFFF7, SpeedMostNeg, 15'd101),
              3'b110, ErrOverSpeed, ModeError, 8'd2, 3'b110),
      row_exp(row_chk(32'h0000_03D3, 16'h0000, 16'h000A, 16'h0000, 15'd101),
              3'b000, ErrOverSpeed, ModeError, 8'd1, 3'b000),
      row_exp(row_chk(32'h0000_03D4, 16'h0000, 16'hFFFF, 16'h0000, 15'd101),
              3'b000, ErrNone, ModeRun, 8'd0, 3'b010),
      row_exp(row_chk(32'h0000_03D5, 16'h0000, 16'h0000, 16'h0000, 15'd100),
              3'b000, ErrNone, ModeRun, 8'd0, 3'b000),
      // Climb past the lock count.
      row_exp(row_chk(32'd10, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
              3'b100, ErrOverSpeed, ModeError, 8'd1, 3'b100),
      row_chk(32'd11, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
      row_chk(32'd12, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
      row_chk(32'd13, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
      row_exp(row_chk(32'd14, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
              3'b100, ErrOverSpeed, ModeError, 8'd5, 3'b100),
      row_exp(row_chk(32'd15, 16'h0000, 16'h0000, SpeedMostNeg, 15'd0),
              3'b100, ErrOverSpeed, ModeLocked, 8'd6, 3'b100),
      row_exp(row_chk(32'd16, 16'h0000, 16'h0000, 16'h0000, 15'd0),
              3'b000, ErrOverSpeed, ModeLocked, 8'd5, 3'b000),
      row_exp(row_chk(32'hFFFF_FFFF, 16'hFFFF, SpeedMostNeg, 16'h0000, 15'd0),
              3'b000, ErrOverSpeed, ModeLocked, 8'd4, 3'b000),
      // Over-current needs a limit below full scale.
      row_lim(RegCurrentLimit, 16'd0),
      row_exp(row_chk(32'd17, 16'h0001, 16'h0000, 16'h0000, 15'd0),
              3'b001, ErrOverCurr, ModeError, 8'd5, 3'b001),
      row_exp(row_chk(32'd18, 16'h0000, 16'h0000, 16'h0000, 15'd0),
              3'b000, ErrOverCurr, ModeError, 8'd4, 3'b000),
      row_exp(row_chk(32'd19, 16'hFFFF, 16'h0000, 16'h7FFF, 15'h7FFF),
              3'b001, ErrOverCurr, ModeError, 8'd5, 3'b011)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        RowLimit: begin
          settle();
          write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
        end
        RowTyped: send_check(dir_rows[i].chk, 1'b1, dir_rows[i].res);
        default:  send_check(dir_rows[i].chk, 1'b0, '0);
      endcase
    end

    // Drive the error counter into saturation with locking disabled,
    // then bring it down a little with clean checks.
    settle();
    write_reg(RegLockCount, 16'd255);
    repeat (FullItems) begin
      it                  = random_check();
      it.measured_current = 16'($urandom_range(1, 16'hFFFF));
      send_check(it, 1'b0, '0);
    end
    repeat (20) begin
      it                  = random_check();
      it.measured_current = '0;
      it.reported_speed   = '0;
      it.speed_cmd        = '0;
      send_check(it, 1'b0, '0);
    end

    // Random phases over a spread of limit settings.
    for (phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0: load_limits('0, '0, '0, '0, '0, '0);
        1: begin
          load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          write_reg(RegBeyondLo, 16'($urandom()));
          write_reg(RegBeyondHi, 16'($urandom()));
        end
        2: load_limits(CurrentLimitRst, OverSpeedLimRst, StallTgtMinRst,
                       StallSpeedMaxRst, StallTimeRst, LockCountRst);
        default: load_limits(16'($urandom()), 16'($urandom()),
                             16'($urandom_range(0, 2000)), 16'($urandom_range(0, 200)),
                             ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                             16'($urandom_range(0, 3000)),
                             ($urandom_range(0, 7) == 0) ? 16'(254 + $urandom_range(0, 1)) :
                             16'($urandom_range(0, 12)));
      endcase

      // Phase 3 backs up the result side while checks keep coming;
      // phase 4 runs with no idling at all.
      sender_steady   = (phase == 3) || (phase == 4);
      receiver_steady = (phase == 4);
      hold_off        = (phase == 3);

      repeat (PhaseItems) send_check(random_check(), 1'b0, '0);
    end

    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
